// File: rtl/core/latency_histogram_percentile_unit_defines.svh
// Assertion helpers used by the checker file of the histogram unit.
`ifndef LATENCY_HISTOGRAM_PERCENTILE_UNIT_DEFINES_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LHP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram unit check failed");

// Antecedent implies consequent in the following cycle.
`define LHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram unit check failed");

`endif

// File: rtl/core/lhp_pkg.sv
`timescale 1ns / 1ps
package lhp_pkg;

  localparam int NUM_BUCKETS    = 6;
  localparam int NUM_BOUND_REGS = 5;
  localparam int BKT_IDX_W      = $clog2(NUM_BUCKETS);
  localparam int CFG_IDX_W      = 3;
  localparam int LAT_W          = 32;
  localparam int PCT_W          = 7;
  localparam int RANK_W         = LAT_W + PCT_W;

  localparam logic [BKT_IDX_W-1:0] LAST_BKT = BKT_IDX_W'(NUM_BUCKETS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_PERCENTILE = CFG_IDX_W'(5);

  localparam logic [PCT_W-1:0] PCT_MIN   = PCT_W'(1);
  localparam logic [PCT_W-1:0] PCT_MAX   = PCT_W'(100);
  localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(95);

  localparam logic [LAT_W-1:0] BOUND_RESET [NUM_BOUND_REGS] = '{
    LAT_W'(1000), LAT_W'(5000), LAT_W'(10000), LAT_W'(20000), LAT_W'(50000)
  };

  typedef logic [LAT_W-1:0] lat_t;

  typedef struct packed {
    logic action;
    lat_t elapsed_us;
  } in_word_t;

  typedef struct packed {
    lat_t percentile_upper_us;
    lat_t max_us;
    lat_t sample_count;
  } out_word_t;

endpackage

// File: rtl/core/latency_histogram_percentile_unit.sv
`timescale 1ns / 1ps
// Latency histogram with a percentile estimate. Each input word records one latency
// sample or clears the statistics, and each gives exactly one output word holding the
// percentile bucket bound, the largest latency and the sample count. Words are handled
// one at a time by a sequencer: a record first steps through the bounds to find its
// bucket, then forms the rank product and adds up the bucket counts in order until the
// running sum reaches the rank; a clear resets the statistics and goes straight to the
// result. A finished word waits in the sequencer until the output register is free, then
// in the output register, and the next input word is taken once the sequencer has handed over.
// Configuration writes are taken in any cycle and are meant for idle periods.
module latency_histogram_percentile_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lhp_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lhp_pkg::out_word_t            out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  lhp_pkg::lat_t                 cfg_data
);
  import lhp_pkg::*;

  lat_t             bounds [NUM_BUCKETS-1];
  logic [PCT_W-1:0] pct_eff;
  logic             eng_idle;
  logic             eng_done;
  logic             slot_free;
  out_word_t        eng_result;
  logic             out_valid_r;
  out_word_t        out_word_r;

  assign cfg_ready = rst_n;
  assign in_ready  = eng_idle && rst_n;
  assign slot_free = !out_valid_r || out_ready;

  lhp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .bounds   (bounds),
    .pct_eff  (pct_eff)
  );

  lhp_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && eng_idle),
    .in_word   (in_word),
    .bounds    (bounds),
    .pct_eff   (pct_eff),
    .slot_free (slot_free),
    .idle      (eng_idle),
    .done      (eng_done),
    .result    (eng_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (eng_done) begin
        out_valid_r <= 1'b1;
        out_word_r  <= eng_result;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: rtl/core/lhp_cfg_regs.sv
`timescale 1ns / 1ps
module lhp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [lhp_pkg::CFG_IDX_W-1:0] wr_index,
  input  lhp_pkg::lat_t                 wr_data,
  output lhp_pkg::lat_t                 bounds [lhp_pkg::NUM_BUCKETS-1],
  output logic [lhp_pkg::PCT_W-1:0]     pct_eff
);
  import lhp_pkg::*;

  lat_t             bound_r [NUM_BOUND_REGS];
  logic [PCT_W-1:0] pct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r <= BOUND_RESET;
      pct_r   <= PCT_RESET;
    end else if (wr_en) begin
      for (int i = 0; i < NUM_BOUND_REGS; i++) begin
        if (wr_index == CFG_IDX_W'(i)) begin
          bound_r[i] <= wr_data;
        end
      end
      if (wr_index == REG_PERCENTILE) begin
        pct_r <= wr_data[PCT_W-1:0];
      end
    end
  end

  // Bounded buckets without a register of their own get an all-ones bound and take every sample that reaches them.
  for (genvar g = 0; g < NUM_BUCKETS - 1; g++) begin : g_slot
    if (g < NUM_BOUND_REGS) begin : g_reg
      assign bounds[g] = bound_r[g];
    end else begin : g_open
      assign bounds[g] = '1;
    end
  end

  always_comb begin
    priority if (pct_r < PCT_MIN) begin
      pct_eff = PCT_MIN;
    end else if (pct_r > PCT_MAX) begin
      pct_eff = PCT_MAX;
    end else begin
      pct_eff = pct_r;
    end
  end

endmodule

// File: rtl/core/lhp_engine.sv
`timescale 1ns / 1ps
module lhp_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  lhp_pkg::in_word_t         in_word,
  input  lhp_pkg::lat_t             bounds [lhp_pkg::NUM_BUCKETS-1],
  input  logic [lhp_pkg::PCT_W-1:0] pct_eff,
  input  logic                      slot_free,
  output logic                      idle,
  output logic                      done,
  output lhp_pkg::out_word_t        result
);
  import lhp_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PICK, S_PROD, S_ACC, S_CMP, S_DONE} state_t;

  state_t                state_r;
  lat_t                  counts_r [NUM_BUCKETS];
  lat_t                  total_r;
  lat_t                  max_r;
  lat_t                  lat_r;
  lat_t                  acc_r;
  lat_t                  res_r;
  logic [RANK_W-1:0]     prod_r;
  logic [BKT_IDX_W-1:0]  idx_r;
  logic [RANK_W-1:0]     acc100;
  logic                  above_bound;

  // Comparing 100 * sum against count * percentile avoids dividing for the rank.
  assign acc100 = (RANK_W'(acc_r) << 6) + (RANK_W'(acc_r) << 5) + (RANK_W'(acc_r) << 2);
  assign above_bound = (idx_r != LAST_BKT) && (lat_r > bounds[idx_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      counts_r <= '{default: '0};
      total_r  <= '0;
      max_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_word.action) begin
              counts_r <= '{default: '0};
              total_r  <= '0;
              max_r    <= '0;
              state_r  <= S_PROD;
            end else begin
              total_r <= total_r + lat_t'(1);
              if (in_word.elapsed_us > max_r) begin
                max_r <= in_word.elapsed_us;
              end
              lat_r   <= in_word.elapsed_us;
              idx_r   <= '0;
              state_r <= S_PICK;
            end
          end
        end
        S_PICK: begin
          if (above_bound) begin
            idx_r <= idx_r + BKT_IDX_W'(1);
          end else begin
            counts_r[idx_r] <= counts_r[idx_r] + lat_t'(1);
            state_r         <= S_PROD;
          end
        end
        S_PROD: begin
          if (total_r == '0) begin
            res_r   <= '0;
            state_r <= S_DONE;
          end else begin
            prod_r  <= RANK_W'(total_r) * RANK_W'(pct_eff);
            acc_r   <= '0;
            idx_r   <= '0;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          acc_r   <= acc_r + counts_r[idx_r];
          state_r <= S_CMP;
        end
        S_CMP: begin
          priority if (acc100 >= prod_r) begin
            res_r   <= (idx_r == LAST_BKT) ? max_r : bounds[idx_r];
            state_r <= S_DONE;
          end else if (idx_r == LAST_BKT) begin
            res_r   <= max_r;
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + BKT_IDX_W'(1);
            state_r <= S_ACC;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE) && slot_free;

  always_comb begin
    result.percentile_upper_us = res_r;
    result.max_us              = max_r;
    result.sample_count        = total_r;
  end

endmodule

// File: rtl/core/lhp_checker.sv
`timescale 1ns / 1ps
`include "latency_histogram_percentile_unit_defines.svh"
module lhp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lhp_pkg::out_word_t out_word
);
  import lhp_pkg::*;

  `LHP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  `LHP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `LHP_ASSERT_NOW(a_empty_estimate, out_valid && (out_word.sample_count == '0),
                  out_word.percentile_upper_us == '0)

endmodule

bind latency_histogram_percentile_unit lhp_checker u_lhp_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lhp_pkg::*;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BOUND_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A    = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B    = CFG_IDX_W'(7);

  localparam int          RANDOM_PHASES   = 7;
  localparam int          WORDS_PER_PHASE = 135;
  localparam int          SETTLE_CYCLES   = 30;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int          REPORT_LIMIT    = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  lat_t                 cfg_data = '0;

  in_word_t  sample_queue[$];
  out_word_t expected_summaries[$];

  lat_t             bucket_bounds [NUM_BOUND_REGS] = BOUND_RESET;
  logic [PCT_W-1:0] rank_percent = PCT_RESET;
  lat_t             bucket_tally [NUM_BUCKETS] = '{default: '0};
  lat_t             sample_total = '0;
  lat_t             peak_latency = '0;

  logic        no_idle = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned quiet_cycles = 0;
  int          mismatch_count = 0;

  latency_histogram_percentile_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_word_t advance_histogram(in_word_t w);
    out_word_t        summary;
    logic [63:0]      rank_wide;
    lat_t             rank;
    lat_t             running;
    logic [PCT_W-1:0] pct;
    int               b;
    bit               found;
    if (w.action == ACT_CLEAR) begin
      bucket_tally = '{default: '0};
      sample_total = '0;
      peak_latency = '0;
    end else begin
      sample_total = sample_total + 1;
      if (w.elapsed_us > peak_latency) begin
        peak_latency = w.elapsed_us;
      end
      b = 0;
      while (b < NUM_BUCKETS - 1 && w.elapsed_us > bucket_bounds[b]) begin
        b++;
      end
      bucket_tally[b] = bucket_tally[b] + 1;
    end
    summary.max_us              = peak_latency;
    summary.sample_count        = sample_total;
    summary.percentile_upper_us = '0;
    if (sample_total != '0) begin
      pct = rank_percent;
      if (pct < PCT_MIN) begin
        pct = PCT_MIN;
      end
      if (pct > PCT_MAX) begin
        pct = PCT_MAX;
      end
      rank_wide = (64'(sample_total) * 64'(pct) + 64'd99) / 64'd100;
      rank      = rank_wide[LAT_W-1:0];
      running   = '0;
      found     = 1'b0;
      summary.percentile_upper_us = peak_latency;
      for (int i = 0; i < NUM_BUCKETS && !found; i++) begin
        running = running + bucket_tally[i];
        if (running >= rank) begin
          found = 1'b1;
          if (i < NUM_BUCKETS - 1) begin
            summary.percentile_upper_us = bucket_bounds[i];
          end
        end
      end
    end
    return summary;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic lat_t pick_latency();
    int unsigned k;
    int unsigned r;
    k = $urandom_range(0, NUM_BOUND_REGS - 1);
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: return bucket_bounds[k] + lat_t'($urandom_range(0, 2)) - lat_t'(1);
      3, 4:    return lat_t'($urandom_range(0, bucket_bounds[k]));
      5:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return lat_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, lat_t got, lat_t want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  task automatic queue_sample(logic action, lat_t us);
    in_word_t w;
    w.action     = action;
    w.elapsed_us = us;
    sample_queue.push_back(w);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, lat_t data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < CFG_IDX_W'(NUM_BOUND_REGS)) begin
      bucket_bounds[idx] = data;
    end else if (idx == REG_PERCENTILE) begin
      rank_percent = data[PCT_W-1:0];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(int n);
    lat_t             b [NUM_BOUND_REGS];
    logic [PCT_W-1:0] pct;
    lat_t             pct_data;
    case (n)
      1: begin
        b   = '{32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000};
        pct = PCT_W'(50);
      end
      2: begin
        b   = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        pct = PCT_MAX;
      end
      3: begin
        b   = '{32'd500, 32'd100, 32'd2000, 32'd50, 32'd100000};
        pct = PCT_MIN;
      end
      4: begin
        foreach (b[i]) b[i] = lat_t'($urandom_range(0, 200000));
        pct = PCT_W'(0);
      end
      5: begin
        b   = '{32'hFFFF_FFFF, 32'd0, 32'd5, 32'd3, 32'd0};
        pct = PCT_W'(127);
      end
      6: begin
        b   = '{32'd1, 32'd2, 32'd3, 32'd4, 32'd5};
        pct = PCT_W'(101);
      end
      default: begin
        b   = BOUND_RESET;
        pct = PCT_W'(99);
      end
    endcase
    foreach (b[i]) write_register(REG_BOUND_BASE + CFG_IDX_W'(i), b[i]);
    pct_data            = lat_t'($urandom);
    pct_data[PCT_W-1:0] = pct;
    write_register(REG_PERCENTILE, pct_data);
    if (n == 6) begin
      write_register(REG_SPARE_A, lat_t'($urandom));
      write_register(REG_SPARE_B, lat_t'($urandom));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || expected_summaries.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_summaries.push_back(advance_histogram(in_word));
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_word  <= sample_queue.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_summaries.size() == 0) begin
          report_mismatch("word with nothing expected", out_word.sample_count, '0);
        end else begin
          want = expected_summaries.pop_front();
          if (out_word.percentile_upper_us !== want.percentile_upper_us) begin
            report_mismatch("percentile_upper_us", out_word.percentile_upper_us,
                            want.percentile_upper_us);
          end
          if (out_word.max_us !== want.max_us) begin
            report_mismatch("max_us", out_word.max_us, want.max_us);
          end
          if (out_word.sample_count !== want.sample_count) begin
            report_mismatch("sample_count", out_word.sample_count, want.sample_count);
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("latency_histogram_percentile_unit: mismatch");
      $finish;
    end
  end

  initial begin
    lat_t edge_lats [] = '{32'd0, 32'd1000, 32'd1001, 32'd5000, 32'd5001, 32'd10000,
                           32'd20000, 32'd50000, 32'd50001, 32'hFFFF_FFFF, 32'd7};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (edge_lats[i]) queue_sample(ACT_RECORD, edge_lats[i]);
    queue_sample(ACT_CLEAR, 32'hFFFF_FFFF);
    queue_sample(ACT_CLEAR, 32'h0000_0000);
    queue_sample(ACT_RECORD, 32'h8000_0000);
    queue_sample(ACT_RECORD, 32'd1);
    queue_sample(ACT_RECORD, 32'd999);
    queue_sample(ACT_CLEAR, 32'h5555_AAAA);
    queue_sample(ACT_RECORD, 32'd50000);
    wait_drained();

    // Every phase drains completely before the registers change, so the
    // registers are written only after all outstanding words have come out.
    for (int n = 1; n <= RANDOM_PHASES; n++) begin
      apply_setting(n);
      no_idle <= (n == 3);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if ($urandom_range(0, 99) < 3) begin
          queue_sample(ACT_CLEAR, lat_t'($urandom));
        end else begin
          queue_sample(ACT_RECORD, pick_latency());
        end
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_summaries.size() == 0) begin
      $display("latency_histogram_percentile_unit: match");
    end else begin
      $display("latency_histogram_percentile_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/lhp_pkg.sv
rtl/core/lhp_cfg_regs.sv
rtl/core/lhp_engine.sv
rtl/core/latency_histogram_percentile_unit.sv
rtl/core/lhp_checker.sv
test/tb_top.sv
